### rtl/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared types and constants for the hue reduction and the color pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsvc_pkg;

	localparam int HUE_W     = 16;
	localparam int CHAN_W    = 8;
	localparam int SECTOR_W  = 3;
	localparam int PROD_W    = 2 * CHAN_W;

	localparam logic [SECTOR_W-1:0] SECT_RED_YELLOW    = 3'd0;
	localparam logic [SECTOR_W-1:0] SECT_YELLOW_GREEN  = 3'd1;
	localparam logic [SECTOR_W-1:0] SECT_GREEN_CYAN    = 3'd2;
	localparam logic [SECTOR_W-1:0] SECT_CYAN_BLUE     = 3'd3;
	localparam logic [SECTOR_W-1:0] SECT_BLUE_MAGENTA  = 3'd4;
	localparam logic [SECTOR_W-1:0] SECT_MAGENTA_RED   = 3'd5;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [CHAN_W-1:0]   frac;
	} hue_pos_t;

endpackage

### rtl/hsvc_hsv_if.sv
// ----------------------------------------------------------------------------
// HSV word channel
// Valid/ready channel that carries one HSV color per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hsvc_hsv_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  hue_word;
	logic [7:0]          saturation;
	logic [7:0]          brightness;

	modport source (output valid, output hue_word, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue_word, input saturation, input brightness,
		output ready);
endinterface

### rtl/hsvc_rgb_if.sv
// ----------------------------------------------------------------------------
// RGB word channel
// Valid/ready channel that carries one 8-bit RGB color per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hsvc_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/hsvc_hue_reduce.sv
// ----------------------------------------------------------------------------
// Hue reduction
// Maps a signed hue onto the range 0 to 1535 by true modulo and splits it
// into a sector number and a position within the sector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsvc_hue_reduce (
	input  logic signed [hsvc_pkg::HUE_W-1:0] hue_word,
	output hsvc_pkg::hue_pos_t                pos
);
	import hsvc_pkg::*;

	// The offset is a multiple of the hue period that makes every hue positive.
	localparam logic [HUE_W:0] HUE_OFFSET = 17'd33792;

	logic [HUE_W:0]  shifted;
	logic [7:0]      high_part;
	logic [15:0]     third_prod;
	logic [6:0]      third;
	logic [7:0]      third_x3;
	logic [1:0]      rem3;
	logic [10:0]     reduced;

	// The period is three times 512, so only the bits above bit 8 need a modulo by three.
	always_comb begin
		shifted    = {hue_word[HUE_W-1], hue_word} + HUE_OFFSET;
		high_part  = shifted[HUE_W:9];
		third_prod = 16'(high_part) * 16'd171;
		third      = third_prod[15:9];
		third_x3   = {third, 1'b0} + {1'b0, third};
		rem3       = 2'(high_part - third_x3);
		reduced    = {rem3, shifted[8:0]};
		pos.sector = reduced[10:8];
		pos.frac   = reduced[7:0];
	end
endmodule

### rtl/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// An accepted HSV word is registered in stages s1 to s5; s5 drives the RGB word.
// Throughput: one word per cycle unless the output stalls; each stage holds one
// word and moves it on once the next stage is free; bubbles close up in stalls.
// The longest path is the 16 by 9 bit product in the second stage.
// Reset clears the valid bits of all stages; the data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit (
	input  logic   clk,
	input  logic   arst_n,
	hsvc_hsv_if.sink   pixel_hsv,
	hsvc_rgb_if.source pixel_rgb
);
	import hsvc_pkg::*;

	function automatic logic [CHAN_W-1:0] div255_est(input logic [PROD_W-1:0] x);
		logic [24:0] sum;
		sum = {1'b0, x, 8'b0} + 25'(x);
		return sum[23:16];
	endfunction

	// Returns the corrected quotient and, in the top bit, whether a remainder is left.
	function automatic logic [CHAN_W:0] div255_fix(input logic [PROD_W-1:0] x,
		input logic [CHAN_W-1:0] q);
		logic [PROD_W-1:0] r;
		logic [CHAN_W-1:0] qc;
		logic              nz;
		r = x - ({q, 8'b0} - PROD_W'(q));
		if (r >= 16'd255) begin
			qc = CHAN_W'(q + 8'd1);
			nz = (r != 16'd255);
		end else begin
			qc = q;
			nz = (r != 16'd0);
		end
		return {nz, qc};
	endfunction

	hue_pos_t pos;

	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic en1, en2, en3, en4, en5;

	logic [SECTOR_W-1:0] sector_s1, sector_s2, sector_s3, sector_s4;
	logic [CHAN_W-1:0]   frac_s1;
	logic [CHAN_W-1:0]   val_s1, val_s2, val_s3, val_s4;
	logic [PROD_W-1:0]   prod_s1, prod_s2, prod_s3;
	logic [PROD_W-1:0]   rise_num_s2, fall_num_s2, rise_num_s3, fall_num_s3;
	logic [CHAN_W-1:0]   full_est_s3, rise_est_s3, fall_est_s3;
	logic [CHAN_W-1:0]   full_s4, rise_s4, fall_s4, ceil_s4;
	logic [CHAN_W-1:0]   red_s5, green_s5, blue_s5;

	logic [23:0]       rise_mul;
	logic [23:0]       fall_mul;
	logic [CHAN_W:0]   full_fix, rise_fix, fall_fix;
	logic [CHAN_W-1:0] base, r_term, g_term, b_term;

	hsvc_hue_reduce u_hue_reduce (
		.hue_word (pixel_hsv.hue_word),
		.pos      (pos)
	);

	assign en5 = !v5_q || pixel_rgb.ready;
	assign en4 = !v4_q || en5;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;

	assign pixel_hsv.ready = en1;
	assign pixel_rgb.valid = v5_q;
	assign pixel_rgb.red   = red_s5;
	assign pixel_rgb.green = green_s5;
	assign pixel_rgb.blue  = blue_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (en1) v1_q <= pixel_hsv.valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sector_s1 <= pos.sector;
			frac_s1   <= pos.frac;
			val_s1    <= pixel_hsv.brightness;
			prod_s1   <= PROD_W'(pixel_hsv.brightness) * PROD_W'(pixel_hsv.saturation);
		end
	end

	always_comb begin
		rise_mul = 24'(prod_s1) * 24'(frac_s1);
		fall_mul = 24'(prod_s1) * 24'(9'd256 - {1'b0, frac_s1});
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sector_s2   <= sector_s1;
			val_s2      <= val_s1;
			prod_s2     <= prod_s1;
			rise_num_s2 <= rise_mul[23:8];
			fall_num_s2 <= fall_mul[23:8];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sector_s3   <= sector_s2;
			val_s3      <= val_s2;
			prod_s3     <= prod_s2;
			rise_num_s3 <= rise_num_s2;
			fall_num_s3 <= fall_num_s2;
			full_est_s3 <= div255_est(prod_s2);
			rise_est_s3 <= div255_est(rise_num_s2);
			fall_est_s3 <= div255_est(fall_num_s2);
		end
	end

	always_comb begin
		full_fix = div255_fix(prod_s3, full_est_s3);
		rise_fix = div255_fix(rise_num_s3, rise_est_s3);
		fall_fix = div255_fix(fall_num_s3, fall_est_s3);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			full_s4   <= full_fix[CHAN_W-1:0];
			rise_s4   <= rise_fix[CHAN_W-1:0];
			fall_s4   <= fall_fix[CHAN_W-1:0];
			ceil_s4   <= CHAN_W'(full_fix[CHAN_W-1:0] + {7'd0, full_fix[CHAN_W]});
		end
	end

	always_comb begin
		base = val_s4 - ceil_s4;
		case (sector_s4)
			SECT_RED_YELLOW: begin
				r_term = full_s4;
				g_term = rise_s4;
				b_term = '0;
			end
			SECT_YELLOW_GREEN: begin
				r_term = fall_s4;
				g_term = full_s4;
				b_term = '0;
			end
			SECT_GREEN_CYAN: begin
				r_term = '0;
				g_term = full_s4;
				b_term = rise_s4;
			end
			SECT_CYAN_BLUE: begin
				r_term = '0;
				g_term = fall_s4;
				b_term = full_s4;
			end
			SECT_BLUE_MAGENTA: begin
				r_term = rise_s4;
				g_term = '0;
				b_term = full_s4;
			end
			default: begin
				r_term = full_s4;
				g_term = '0;
				b_term = fall_s4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= r_term + base;
			green_s5 <= g_term + base;
			blue_s5  <= b_term + base;
		end
	end

`ifndef NO_ASSERTIONS
	a_ready_follows_sink: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_rgb.ready |-> pixel_hsv.ready)
		else $error("Input is stalled although the output side is ready.");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> (sector_s1 <= SECT_MAGENTA_RED))
		else $error("Reduced hue falls outside the six sectors.");

	a_stall_keeps_word: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_q && v5_q && !pixel_rgb.ready) |=> v4_q)
		else $error("A stalled word was dropped from the fourth stage.");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_q && en5) |=> v5_q)
		else $error("A word failed to reach the output register.");
`endif
endmodule
